FILE: design/utf8vr_pkg.sv
`default_nettype none
package utf8vr_pkg;

   // byte classes of the strict UTF-8 decoder
   typedef enum logic [3:0] {
      CLS_ASCII   = 4'd0,   // 00-7F
      CLS_CONT_8  = 4'd1,   // 80-8F
      CLS_CONT_9  = 4'd2,   // 90-9F
      CLS_CONT_A  = 4'd3,   // A0-BF
      CLS_INVALID = 4'd4,   // C0-C1, F5-FF
      CLS_LEAD_2  = 4'd5,   // C2-DF
      CLS_E0      = 4'd6,
      CLS_LEAD_3  = 4'd7,   // E1-EC, EE-EF
      CLS_ED      = 4'd8,
      CLS_F0      = 4'd9,
      CLS_LEAD_4  = 4'd10,  // F1-F3
      CLS_F4      = 4'd11
   } byte_class_type;

   localparam int unsigned NUM_CLASSES = 12;
   localparam int unsigned NUM_STATES  = 8;

   // decoder state codes; next-state values carry one more bit for the error code
   localparam logic [2:0] ST_START = 3'd0;
   localparam logic [3:0] NS_START = 4'd0;
   localparam logic [3:0] NS_ERROR = 4'd8;

   // next state [class][state]; states start, A..G; 8 = error
   localparam logic [3:0] TRANS_TABLE [NUM_CLASSES][NUM_STATES] = '{
      '{4'd0, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8},
      '{4'd8, 4'd0, 4'd1, 4'd8, 4'd1, 4'd2, 4'd8, 4'd2},
      '{4'd8, 4'd0, 4'd1, 4'd8, 4'd1, 4'd2, 4'd2, 4'd8},
      '{4'd8, 4'd0, 4'd1, 4'd1, 4'd8, 4'd2, 4'd2, 4'd8},
      '{4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8},
      '{4'd1, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8},
      '{4'd3, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8},
      '{4'd2, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8},
      '{4'd4, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8},
      '{4'd6, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8},
      '{4'd5, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8},
      '{4'd7, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8}
   };

   localparam logic ACTION_BYTE = 1'b0;
   localparam logic ACTION_END  = 1'b1;

   localparam logic [7:0] REPLACEMENT_RESET = 8'h3F;
   localparam logic [7:0] END_REPORT_BYTE   = 8'h00;

   localparam int unsigned HELD_DEPTH = 3;

   typedef struct packed {
      logic       action;
      logic [7:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_end_report;
      logic       text_failed;
      logic       run_last;
   } rsp_payload_type;

   typedef logic [7:0] csr_payload_type;

   // one queued work entry: up to four result bytes of one input item
   typedef struct packed {
      logic [3:0][7:0] entry_bytes;
      logic [1:0]      last_idx;
      logic            is_end;
      logic            failed;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } push_type;

   typedef struct packed {
      logic    full;
      logic    empty;
   } q_status_type;

   function automatic byte_class_type byte_class(input logic [7:0] b);
      byte_class_type cls;
      if (b < 8'h80)       cls = CLS_ASCII;
      else if (b < 8'h90)  cls = CLS_CONT_8;
      else if (b < 8'hA0)  cls = CLS_CONT_9;
      else if (b < 8'hC0)  cls = CLS_CONT_A;
      else if (b < 8'hC2)  cls = CLS_INVALID;
      else if (b < 8'hE0)  cls = CLS_LEAD_2;
      else if (b == 8'hE0) cls = CLS_E0;
      else if (b == 8'hED) cls = CLS_ED;
      else if (b < 8'hF0)  cls = CLS_LEAD_3;
      else if (b == 8'hF0) cls = CLS_F0;
      else if (b < 8'hF4)  cls = CLS_LEAD_4;
      else if (b == 8'hF4) cls = CLS_F4;
      else                 cls = CLS_INVALID;
      return cls;
   endfunction

   // bytes that never start anything: 80-C1 and F5-FF
   function automatic logic in_skip_set(input byte_class_type cls);
      return (cls == CLS_CONT_8) || (cls == CLS_CONT_9) ||
             (cls == CLS_CONT_A) || (cls == CLS_INVALID);
   endfunction

endpackage
`default_nettype wire

FILE: design/utf8vr_stream_if.sv
`default_nettype none
interface utf8vr_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: design/utf8vr_front.sv
`default_nettype none
module utf8vr_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   utf8vr_stream_if.sink                  req_if,
   input  wire logic [7:0]                rep_byte,
   input  wire utf8vr_pkg::q_status_type  q_status,
   output utf8vr_pkg::push_type           q_push
);

   logic [2:0] state_ff, state_in;
   logic [7:0] held_ff [utf8vr_pkg::HELD_DEPTH];
   logic [7:0] held_in [utf8vr_pkg::HELD_DEPTH];
   logic [1:0] held_cnt_ff, held_cnt_in;
   logic       skip_ff, skip_in;
   logic       failed_ff, failed_in;

   logic                       accept;
   logic [7:0]                 b;
   utf8vr_pkg::byte_class_type cls;
   logic                       skip_set;
   logic [3:0]                 ns;
   logic [3:0]                 ns_start;
   logic                       push;
   utf8vr_pkg::cmd_type        cmd;

   assign req_if.ready = !q_status.full;
   assign accept       = req_if.valid && req_if.ready;
   assign b            = req_if.payload.data_byte;
   assign cls          = utf8vr_pkg::byte_class(b);
   assign skip_set     = utf8vr_pkg::in_skip_set(cls);
   assign ns           = utf8vr_pkg::TRANS_TABLE[cls][state_ff];
   assign ns_start     = utf8vr_pkg::TRANS_TABLE[cls][utf8vr_pkg::ST_START];

   // classify one item: next decoder state and the results it releases
   always_comb begin
      state_in    = state_ff;
      held_in     = held_ff;
      held_cnt_in = held_cnt_ff;
      skip_in     = skip_ff;
      failed_in   = failed_ff;
      push        = 1'b0;
      cmd         = '0;
      if (req_if.payload.action == utf8vr_pkg::ACTION_END) begin
         // close the text; an open sequence first gives one replacement
         push       = 1'b1;
         cmd.is_end = 1'b1;
         cmd.failed = failed_ff || (state_ff != utf8vr_pkg::ST_START);
         if (state_ff != utf8vr_pkg::ST_START) begin
            cmd.entry_bytes[0] = rep_byte;
            cmd.entry_bytes[1] = utf8vr_pkg::END_REPORT_BYTE;
            cmd.last_idx       = 2'd1;
         end else begin
            cmd.entry_bytes[0] = utf8vr_pkg::END_REPORT_BYTE;
            cmd.last_idx       = 2'd0;
         end
         state_in    = utf8vr_pkg::ST_START;
         held_cnt_in = 2'd0;
         skip_in     = 1'b0;
         failed_in   = 1'b0;
      end else if (skip_ff && skip_set) begin
         // dropped silently while skipping
         push = 1'b0;
      end else begin
         skip_in = 1'b0;
         if (ns == utf8vr_pkg::NS_ERROR) begin
            push               = 1'b1;
            failed_in          = 1'b1;
            held_cnt_in        = 2'd0;
            state_in           = utf8vr_pkg::ST_START;
            cmd.entry_bytes[0] = rep_byte;
            cmd.last_idx       = 2'd0;
            if (skip_set) begin
               skip_in = 1'b1;
            end else if (ns_start == utf8vr_pkg::NS_START) begin
               cmd.entry_bytes[1] = b;
               cmd.last_idx       = 2'd1;
            end else begin
               // lead byte starts a new sequence from the start state
               held_in[0]  = b;
               held_cnt_in = 2'd1;
               state_in    = ns_start[2:0];
            end
         end else if (ns == utf8vr_pkg::NS_START) begin
            // sequence complete: release held bytes and this one
            push = 1'b1;
            for (int i = 0; i < utf8vr_pkg::HELD_DEPTH; i++) begin
               cmd.entry_bytes[i] = (2'(i) < held_cnt_ff) ? held_ff[i] : b;
            end
            cmd.entry_bytes[3] = b;
            cmd.last_idx       = held_cnt_ff;
            held_cnt_in        = 2'd0;
            state_in           = utf8vr_pkg::ST_START;
         end else begin
            if (held_cnt_ff < 2'(utf8vr_pkg::HELD_DEPTH)) begin
               held_in[held_cnt_ff] = b;
               held_cnt_in          = held_cnt_ff + 2'd1;
            end
            state_in = ns[2:0];
         end
         cmd.failed = failed_in;
      end
   end

   assign q_push.push = accept && push;
   assign q_push.cmd  = cmd;

   // decoder control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= utf8vr_pkg::ST_START;
         held_cnt_ff <= 2'd0;
         skip_ff     <= 1'b0;
         failed_ff   <= 1'b0;
      end else if (accept) begin
         state_ff    <= state_in;
         held_cnt_ff <= held_cnt_in;
         skip_ff     <= skip_in;
         failed_ff   <= failed_in;
      end
   end

   // held sequence bytes, payload only
   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

   // nothing is held outside a sequence
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == utf8vr_pkg::ST_START) |-> (held_cnt_ff == 2'd0))
      else $error("held bytes remain in the start state");

   // skipping only happens after an error returned to the start state
   assert property (@(posedge clock) disable iff (reset)
      skip_ff |-> (state_ff == utf8vr_pkg::ST_START))
      else $error("skipping inside a sequence");

endmodule
`default_nettype wire

FILE: design/utf8vr_queue.sv
`default_nettype none
module utf8vr_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire utf8vr_pkg::push_type      q_push,
   input  wire logic                      pop,
   output utf8vr_pkg::q_status_type       q_status,
   output utf8vr_pkg::cmd_type            head
);

   localparam int unsigned AW = $clog2(DEPTH);

   utf8vr_pkg::cmd_type mem_ff [DEPTH];
   logic [AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [AW:0]         count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign q_status.full  = (count_ff == (AW+1)'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push        = q_push.push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head           = mem_ff[rd_ptr_ff];

   // pointer and fill count update; pointers wrap at DEPTH
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= q_push.cmd;
      end
   end

   // pointers meet exactly when the queue is empty or full
   assert property (@(posedge clock) disable iff (reset)
      (q_status.full || q_status.empty) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue fill count out of step with pointers");

endmodule
`default_nettype wire

FILE: design/utf8vr_back.sv
`default_nettype none
module utf8vr_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire utf8vr_pkg::q_status_type  q_status,
   input  wire utf8vr_pkg::cmd_type       head,
   output logic                           pop,
   utf8vr_stream_if.source                rsp_if
);

   logic [1:0] idx_ff, idx_in;
   logic       last;
   logic       xfer;

   assign last         = (idx_ff == head.last_idx);
   assign rsp_if.valid = !q_status.empty;
   assign xfer         = rsp_if.valid && rsp_if.ready;
   assign pop          = xfer && last;

   // one result per transfer from the head entry
   assign rsp_if.payload.out_byte      = head.entry_bytes[idx_ff];
   assign rsp_if.payload.is_end_report = head.is_end && last;
   assign rsp_if.payload.text_failed   = head.failed;
   assign rsp_if.payload.run_last      = last;

   always_comb begin
      idx_in = idx_ff;
      if (xfer) begin
         idx_in = last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   // the result index never runs past the head entry's count
   assert property (@(posedge clock) disable iff (reset)
      !q_status.empty |-> (idx_ff <= head.last_idx))
      else $error("result index beyond entry");

endmodule
`default_nettype wire

FILE: design/utf8_validate_and_repair_top.sv
// Each result is written to the result queue when its input item is accepted, and offered from there.
// Throughput: one input item per cycle while the result queue has room; results leave
// at one per cycle while the output is ready, so an item releasing k bytes takes k transfers.
// The result queue (QUEUE_DEPTH entries) sets how far input runs ahead of output.
// Reset (synchronous): decoder, skip and failure state and the queue clear;
// the replacement byte returns to 0x3F.
`default_nettype none
module utf8_validate_and_repair_top #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   utf8vr_stream_if.sink    req_if,
   utf8vr_stream_if.source  rsp_if,
   utf8vr_stream_if.sink    csr_if
);

   logic [7:0]               rep_ff;
   utf8vr_pkg::push_type     q_push;
   utf8vr_pkg::q_status_type q_status;
   utf8vr_pkg::cmd_type      head;
   logic                     pop;

   // replacement byte register
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rep_ff <= utf8vr_pkg::REPLACEMENT_RESET;
      end else if (csr_if.valid && csr_if.ready) begin
         rep_ff <= csr_if.payload;
      end
   end

   utf8vr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .rep_byte (rep_ff),
      .q_status (q_status),
      .q_push   (q_push)
   );

   utf8vr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .pop      (pop),
      .q_status (q_status),
      .head     (head)
   );

   utf8vr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .head     (head),
      .pop      (pop),
      .rsp_if   (rsp_if)
   );

endmodule
`default_nettype wire
